// ===== rtl/rel_pkg.sv =====
`timescale 1ns / 1ps

package rel_pkg;

   localparam int LOG_DEPTH = 64;
   localparam int ADDR_W    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int CNT_W     = $clog2(LOG_DEPTH + 1);

   localparam int CAP_W     = 7;
   localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int OFFSET_W  = 8;
   localparam int KEY_W     = 16;
   localparam int BITS_W    = 8;
   localparam int REC_W     = KEY_W + BITS_W;
   localparam int SLOT_W    = 6;
   localparam int TOTAL_W   = 7;
   localparam int STATUS_W  = 2;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USED_W = SLOT_W + TOTAL_W + BITS_W;

   localparam int PADDR_W   = 4;
   localparam int PDATA_W   = 32;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(64);

   // register index, taken from paddr[3:2]
   localparam logic [1:0] REG_CAPACITY       = 2'd0;
   localparam logic [1:0] REG_PREREAD_OFFSET = 2'd1;
   localparam logic [1:0] REG_MERGE_MODE     = 2'd2;

   localparam logic ACT_READ    = 1'b0;
   localparam logic ACT_PREREAD = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_APPEND    = 2'd0,
      ST_DUPLICATE = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

endpackage

// ===== rtl/rel_ram.sv =====
`timescale 1ns / 1ps

module rel_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/read_error_log_dedup.sv =====
`timescale 1ns / 1ps

// Read-error log with de-duplication.
// req channel: one transfer per error event; tuser carries the kind (read or
// pre-read), tdata the position and error bits. rsp channel: one transfer per
// request with status in tuser and slot, entry total and summary in tdata.
// csr: APB registers capacity (0x0), pre-read offset (0x4), merge mode (0x8).
// Records live in a single-port-read memory; a request scans the stored keys
// one per cycle, reads pipelined so a compare happens every cycle.
// A request that finds the log empty or full goes straight to its result;
// else the scan compares k records, where k is the match index + 1 on a
// duplicate and the whole count otherwise. A scan covers at most 63 records,
// as a log holding 64 is full. The next request is taken once the result is
// in the output register, so the log works on one request at a time.
// A result waiting on rsp_tready does not block the next request, but that
// request's result waits for the output register to drain.
// Reset empties the log (count and summary to zero), restores the register
// defaults and drops any result in flight. Memory contents need no clearing.
module read_error_log_dedup (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [15:0] position, [23:16] err_bits
   input  logic [rel_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] action
   input  logic                             req_tuser,

   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [5:0] slot, [12:6] entry_total, [20:13] summary_bits, [23:21] zero
   output logic [rel_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [1:0] status
   output logic [rel_pkg::STATUS_W-1:0]     rsp_tuser,

   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rel_pkg::PADDR_W-1:0]      csr_paddr,
   input  logic [rel_pkg::PDATA_W-1:0]      csr_pwdata,
   output logic [rel_pkg::PDATA_W-1:0]      csr_prdata,
   output logic                             csr_pready
);

   import rel_pkg::*;

   // configuration
   logic [CAP_W-1:0]    capacity_ff, capacity_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic                merge_ff, merge_in;

   // log state
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [BITS_W-1:0]   summary_ff, summary_in;

   // request in progress
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [BITS_W-1:0]   bits_ff, bits_in;
   logic                merge_read_ff, merge_read_in;
   status_type          status_ff, status_in;
   logic [CNT_W-1:0]    issue_ff, issue_in;
   logic                pend_ff, pend_in;
   logic [ADDR_W-1:0]   pend_addr_ff, pend_addr_in;
   logic [ADDR_W-1:0]   slot_ff, slot_in;
   logic [BITS_W-1:0]   match_bits_ff, match_bits_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [TOTAL_W-1:0]  rsp_total_ff, rsp_total_in;
   logic [BITS_W-1:0]   rsp_summary_ff, rsp_summary_in;

   // record memory
   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic [REC_W-1:0]    ram_wr_data;
   logic                ram_rd_en;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [REC_W-1:0]    ram_rd_data;

   logic                csr_wr;
   logic [CMP_W-1:0]    eff_cap;
   logic                log_full;
   logic                last_pend;
   logic                req_preread;
   logic [KEY_W-1:0]    req_position;
   logic [BITS_W-1:0]   req_bits;
   logic [KEY_W-1:0]    req_key;

   rel_ram #(
      .WIDTH (REC_W),
      .DEPTH (LOG_DEPTH)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      capacity_in = capacity_ff;
      offset_in   = offset_ff;
      merge_in    = merge_ff;
      if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_CAPACITY:       capacity_in = csr_pwdata[CAP_W-1:0];
            REG_PREREAD_OFFSET: offset_in   = csr_pwdata[OFFSET_W-1:0];
            REG_MERGE_MODE:     merge_in    = csr_pwdata[0];
            default:            ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_CAPACITY:       csr_prdata = PDATA_W'(capacity_ff);
         REG_PREREAD_OFFSET: csr_prdata = PDATA_W'(offset_ff);
         REG_MERGE_MODE:     csr_prdata = PDATA_W'(merge_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // ---------------- request decode ----------------
   assign req_preread  = (req_tuser == ACT_PREREAD);
   assign req_position = req_tdata[KEY_W-1:0];
   assign req_bits     = req_tdata[KEY_W +: BITS_W];
   assign req_key      = req_preread ? (req_position + KEY_W'(offset_ff)) : req_position;

   assign eff_cap   = (CMP_W'(capacity_ff) < CMP_W'(LOG_DEPTH)) ?
                      CMP_W'(capacity_ff) : CMP_W'(LOG_DEPTH);
   assign log_full  = CMP_W'(count_ff) >= eff_cap;
   assign last_pend = (CNT_W'(pend_addr_ff) + CNT_W'(1)) == count_ff;

   assign req_tready = (state_ff == S_IDLE);

   // ---------------- control ----------------
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      summary_in     = summary_ff;
      key_in         = key_ff;
      bits_in        = bits_ff;
      merge_read_in  = merge_read_ff;
      status_in      = status_ff;
      issue_in       = issue_ff;
      pend_in        = pend_ff;
      pend_addr_in   = pend_addr_ff;
      slot_in        = slot_ff;
      match_bits_in  = match_bits_ff;

      rsp_valid_in   = rsp_valid_ff & ~rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_summary_in = rsp_summary_ff;

      ram_wr_en      = 1'b0;
      ram_wr_addr    = count_ff[ADDR_W-1:0];
      ram_wr_data    = {key_ff, bits_ff};
      ram_rd_en      = 1'b0;
      ram_rd_addr    = issue_ff[ADDR_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               key_in        = req_key;
               bits_in       = req_bits;
               merge_read_in = ~req_preread & merge_ff;
               issue_in      = '0;
               pend_in       = 1'b0;
               slot_in       = '0;
               // merge mode ORs read-kind bits into the summary even when full
               if (~req_preread & merge_ff) begin
                  summary_in = summary_ff | req_bits;
               end
               if (log_full) begin
                  status_in = ST_FULL;
                  state_in  = S_FINISH;
               end else if (count_ff == '0) begin
                  status_in = ST_APPEND;
                  state_in  = S_FINISH;
               end else begin
                  state_in  = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            pend_in = 1'b0;
            if (issue_ff < count_ff) begin
               ram_rd_en    = 1'b1;
               issue_in     = issue_ff + CNT_W'(1);
               pend_in      = 1'b1;
               pend_addr_in = issue_ff[ADDR_W-1:0];
            end
            // compare the entry read last cycle; a stray read after a hit is harmless
            if (pend_ff) begin
               if (ram_rd_data[REC_W-1:BITS_W] == key_ff) begin
                  slot_in       = pend_addr_ff;
                  match_bits_in = ram_rd_data[BITS_W-1:0];
                  status_in     = ST_DUPLICATE;
                  pend_in       = 1'b0;
                  state_in      = S_FINISH;
               end else if (last_pend) begin
                  status_in     = ST_APPEND;
                  pend_in       = 1'b0;
                  state_in      = S_FINISH;
               end
            end
         end

         S_FINISH: begin
            if (~rsp_valid_ff | rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
               case (status_ff)
                  ST_APPEND: begin
                     ram_wr_en      = 1'b1;
                     ram_wr_addr    = count_ff[ADDR_W-1:0];
                     ram_wr_data    = {key_ff, bits_ff};
                     count_in       = count_ff + CNT_W'(1);
                     summary_in     = summary_ff | bits_ff;
                     rsp_slot_in    = SLOT_W'(count_ff);
                     rsp_total_in   = TOTAL_W'(count_ff + CNT_W'(1));
                     rsp_summary_in = summary_ff | bits_ff;
                  end
                  ST_DUPLICATE: begin
                     ram_wr_en      = merge_read_ff;
                     ram_wr_addr    = slot_ff;
                     ram_wr_data    = {key_ff, match_bits_ff | bits_ff};
                     rsp_slot_in    = SLOT_W'(slot_ff);
                     rsp_total_in   = TOTAL_W'(count_ff);
                     rsp_summary_in = summary_ff;
                  end
                  default: begin
                     rsp_slot_in    = '0;
                     rsp_total_in   = TOTAL_W'(count_ff);
                     rsp_summary_in = summary_ff;
                  end
               endcase
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         offset_ff    <= '0;
         merge_ff     <= 1'b0;
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         summary_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         offset_ff    <= offset_in;
         merge_ff     <= merge_in;
         state_ff     <= state_in;
         count_ff     <= count_in;
         summary_ff   <= summary_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      bits_ff        <= bits_in;
      merge_read_ff  <= merge_read_in;
      status_ff      <= status_in;
      issue_ff       <= issue_in;
      pend_addr_ff   <= pend_addr_in;
      slot_ff        <= slot_in;
      match_bits_ff  <= match_bits_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_summary_ff <= rsp_summary_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RSP_USED_W)'(0), rsp_summary_ff, rsp_total_ff,
                        rsp_slot_ff};

endmodule

// ===== rtl/rel_checker.sv =====
`timescale 1ns / 1ps

module rel_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [rel_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic [rel_pkg::STATUS_W-1:0]     rsp_tuser
);

   import rel_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp transfer changed while stalled");

   // nothing is reported in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   // a refused request reports slot zero
   a_full_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_FULL |-> rsp_tdata[SLOT_W-1:0] == '0)
      else $error("refused request with non-zero slot");

   // a request accepted while idle cannot already have its result the next cycle
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result before the log was consulted");

endmodule

bind read_error_log_dedup rel_checker u_rel_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import rel_pkg::*;

   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int HOLD_CYCLES  = 400;
   localparam int PHASE_ITEMS  = 120;

   typedef struct packed {
      logic               action;
      logic [KEY_W-1:0]   position;
      logic [BITS_W-1:0]  err_bits;
   } log_request_type;

   typedef struct packed {
      status_type          status;
      logic [SLOT_W-1:0]   slot;
      logic [TOTAL_W-1:0]  total;
      logic [BITS_W-1:0]   summ;
   } log_outcome_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = ACT_READ;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [PADDR_W-1:0]    csr_paddr = '0;
   logic [PDATA_W-1:0]    csr_pwdata = '0;
   logic [PDATA_W-1:0]    csr_prdata;
   logic                  csr_pready;

   read_error_log_dedup dut (.*);

   always #4 clock = ~clock;

   // predictor state and register shadows
   logic [KEY_W-1:0]   log_keys [LOG_DEPTH];
   logic [BITS_W-1:0]  log_bits [LOG_DEPTH];
   int                 log_count = 0;
   logic [BITS_W-1:0]  err_summary = '0;
   logic [CAP_W-1:0]   cfg_capacity = CAPACITY_RESET;
   logic [OFFSET_W-1:0] cfg_offset = '0;
   logic               cfg_merge = 1'b0;

   log_request_type pending_requests [$];
   log_outcome_type expected_outcomes [$];
   log_request_type offered;
   int  send_wait = 0;
   int  recv_wait = 0;
   int  hold_left = 0;
   int  hold_asked = 0;
   int  hold_served = 0;
   bit  send_idle = 1'b1;
   bit  recv_idle = 1'b1;
   int  errors = 0;
   int  cycles = 0;

   function automatic log_outcome_type apply_log_request(log_request_type rq);
      log_outcome_type r;
      logic [KEY_W-1:0] key;
      int eff_cap;
      bit hit;
      bit merging;
      hit = 1'b0;
      merging = (rq.action == ACT_READ) && cfg_merge;
      eff_cap = (cfg_capacity < LOG_DEPTH) ? cfg_capacity : LOG_DEPTH;
      key = (rq.action == ACT_PREREAD) ? rq.position + KEY_W'(cfg_offset) : rq.position;
      r.slot = '0;
      if (merging) err_summary |= rq.err_bits;
      if (log_count >= eff_cap) begin
         r.status = ST_FULL;
      end else begin
         for (int i = 0; i < log_count; i++) begin
            if (!hit && log_keys[i] == key) begin
               hit = 1'b1;
               r.slot = SLOT_W'(i);
            end
         end
         if (hit) begin
            r.status = ST_DUPLICATE;
            if (merging) log_bits[r.slot] |= rq.err_bits;
         end else begin
            r.status = ST_APPEND;
            r.slot = SLOT_W'(log_count);
            log_keys[log_count] = key;
            log_bits[log_count] = rq.err_bits;
            err_summary |= rq.err_bits;
            log_count++;
         end
      end
      r.total = TOTAL_W'(log_count);
      r.summ = err_summary;
      return r;
   endfunction

   // mostly keys already in the log, so the scan finds duplicates; a few new or random ones
   function automatic log_request_type make_request();
      log_request_type rq;
      logic [KEY_W-1:0] key;
      int pick;
      rq.action = $urandom_range(0, 1) ? ACT_PREREAD : ACT_READ;
      rq.err_bits = ($urandom_range(0, 9) == 0) ? '0 : BITS_W'($urandom);
      pick = $urandom_range(0, 15);
      if (pick <= 1 || log_count == 0)
         key = KEY_W'($urandom);
      else
         key = log_keys[$urandom_range(0, log_count - 1)];
      rq.position = (rq.action == ACT_PREREAD) ? key - KEY_W'(cfg_offset) : key;
      return rq;
   endfunction

   task automatic flag_error(input string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_CAPACITY:       cfg_capacity = value[CAP_W-1:0];
         REG_PREREAD_OFFSET: cfg_offset = value[OFFSET_W-1:0];
         REG_MERGE_MODE:     cfg_merge = value[0];
         default: ;
      endcase
   endtask

   task automatic configure(input int cap, input int offs, input bit merge);
      csr_write(REG_CAPACITY, PDATA_W'(cap));
      csr_write(REG_PREREAD_OFFSET, PDATA_W'(offs));
      csr_write(REG_MERGE_MODE, PDATA_W'(merge));
   endtask

   task automatic queue_request(input logic act, input logic [KEY_W-1:0] pos,
                                input logic [BITS_W-1:0] bits);
      log_request_type rq;
      rq.action = act;
      rq.position = pos;
      rq.err_bits = bits;
      pending_requests.push_back(rq);
   endtask

   task automatic drain();
      while (pending_requests.size() != 0 || req_tvalid || expected_outcomes.size() != 0)
         @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   // request side
   always @(posedge clock) begin
      bit nxt_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_wait = 0;
      end else begin
         nxt_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            expected_outcomes.push_back(apply_log_request(offered));
            nxt_valid = 1'b0;
            send_wait = send_idle ? $urandom_range(0, 11) : 0;
         end
         if (!nxt_valid) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (pending_requests.size() != 0) begin
               offered = pending_requests.pop_front();
               req_tdata <= {offered.err_bits, offered.position};
               req_tuser <= offered.action;
               nxt_valid = 1'b1;
            end
         end
         req_tvalid <= nxt_valid;
      end
   end

   // result side
   always @(posedge clock) begin
      log_outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_outcomes.size() == 0) begin
            flag_error($sformatf("result with nothing outstanding: status %0d data %h",
                                 rsp_tuser, rsp_tdata));
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_tuser !== want.status ||
                rsp_tdata !== {3'b000, want.summ, want.total, want.slot})
               flag_error($sformatf(
                  "exp st %0d slot %0d tot %0d sum %h, got st %0d slot %0d tot %0d sum %h pad %b",
                  want.status, want.slot, want.total, want.summ, rsp_tuser, rsp_tdata[5:0],
                  rsp_tdata[12:6], rsp_tdata[20:13], rsp_tdata[23:21]));
         end
         recv_wait = recv_idle ? $urandom_range(0, 11) : 0;
      end else if (recv_wait > 0) begin
         recv_wait--;
      end
      if (hold_asked != hold_served) begin
         hold_left = HOLD_CYCLES;
         hold_served++;
      end else if (hold_left > 0) begin
         hold_left--;
      end
      rsp_tready <= !reset && recv_wait == 0 && hold_left == 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int caps [12] = '{8, 12, 20, 0, 28, 36, 44, 52, 60, 64, 100, 127};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      // register defaults: empty log, appends, wrap-free duplicates, zero error bits
      queue_request(ACT_READ, 16'h0000, 8'h01);
      queue_request(ACT_READ, 16'hFFFF, 8'h80);
      queue_request(ACT_PREREAD, 16'h0000, 8'h02);
      queue_request(ACT_READ, 16'h0000, 8'hFF);
      queue_request(ACT_PREREAD, 16'hFFFF, 8'h00);
      queue_request(ACT_READ, 16'h1234, 8'h00);
      drain();

      // merge on, pre-read key wraps past 16 bits
      configure(64, 255, 1'b1);
      queue_request(ACT_READ, 16'h0000, 8'h10);
      queue_request(ACT_PREREAD, 16'hFFFF, 8'h04);
      queue_request(ACT_PREREAD, 16'hFF01, 8'h20);
      queue_request(ACT_READ, 16'h00FE, 8'h40);
      queue_request(ACT_PREREAD, 16'hFF00, 8'hFF);
      drain();

      // zero capacity refuses everything; merged reads still reach the summary
      configure(0, 255, 1'b1);
      queue_request(ACT_READ, 16'h5555, 8'h08);
      queue_request(ACT_PREREAD, 16'h5555, 8'hFF);
      drain();
      configure(0, 0, 1'b0);
      queue_request(ACT_READ, 16'hAAAA, 8'hFF);
      drain();

      // capacity above the log depth
      configure(127, 1, 1'b0);
      queue_request(ACT_PREREAD, 16'hFFFF, 8'h01);
      queue_request(ACT_READ, 16'h1234, 8'hAA);
      queue_request(ACT_PREREAD, 16'h8000, 8'h55);
      queue_request(ACT_READ, 16'h7FFF, 8'h00);
      drain();

      for (int p = 0; p < 12; p++) begin
         configure(caps[p], (p == 0) ? 0 : (p == 1) ? 255 : $urandom_range(0, 255),
                   (p % 2 == 1) ? 1'b1 : 1'($urandom_range(0, 1)));
         send_idle = (p % 3 != 2);
         recv_idle = (p % 4 != 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ((p == 2 || p == 7) && n == 30) hold_asked++;
            if (p == 5 && n == 60) drain();
            while (pending_requests.size() >= 2) @(negedge clock);
            pending_requests.push_back(make_request());
         end
         drain();
      end

      repeat (20) @(negedge clock);
      if (errors == 0 && expected_outcomes.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
